[sv/fmpd_pkg.sv]
// Shared constants, types and the arctangent table of the FM phase discriminator.
package fmpd_pkg;

   localparam int FIRST_DECIMATION  = 11;
   localparam int SECOND_DECIMATION = 4;
   localparam int SAMPLE_BITS       = 16;
   localparam int CORDIC_STEPS      = 16;
   localparam int ATAN_ENTRIES      = 24;

   localparam int OUT_W      = 16;
   localparam int CLAMP_W    = OUT_W + 1;
   localparam int ACC_W      = SAMPLE_BITS + $clog2(FIRST_DECIMATION);
   localparam int CNT1_W     = $clog2(FIRST_DECIMATION + 1);
   localparam int CNT2_W     = $clog2(SECOND_DECIMATION + 1);
   localparam int PROD_W     = 2 * ACC_W;
   localparam int SUMP_W     = PROD_W + 1;
   localparam int CORDIC_W   = SUMP_W + 2;
   localparam int Z_W        = 34;
   localparam int ROUND_SH   = 16;
   localparam int ANGLE_W    = Z_W - ROUND_SH;
   localparam int ASUM_W     = ANGLE_W + CNT2_W;
   localparam int AVG_SHIFT  = $clog2(SECOND_DECIMATION + 1) - 1;
   localparam int STEP_W     = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int ATAN_IDX_W = $clog2(ATAN_ENTRIES);

   typedef struct packed {
      logic signed [ACC_W-1:0] re;
      logic signed [ACC_W-1:0] im;
   } fmpd_group_type;

   typedef struct packed {
      logic           valid;
      fmpd_group_type data;
   } fmpd_group_msg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_PREP,
      ST_ROT,
      ST_ITER,
      ST_DONE,
      ST_OUT
   } fmpd_state_type;

   typedef enum logic {
      FMT_Q15  = 1'b0,
      FMT_BYTE = 1'b1
   } fmpd_format_type;

   // Arctangent of 2^-i with pi scaled to 2^31.
   function automatic logic [31:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:  val = 32'h20000000;
         5'd1:  val = 32'h12E4051E;
         5'd2:  val = 32'h09FB385B;
         5'd3:  val = 32'h051111D4;
         5'd4:  val = 32'h028B0D43;
         5'd5:  val = 32'h0145D7E1;
         5'd6:  val = 32'h00A2F61E;
         5'd7:  val = 32'h00517C55;
         5'd8:  val = 32'h0028BE53;
         5'd9:  val = 32'h00145F2F;
         5'd10: val = 32'h000A2F98;
         5'd11: val = 32'h000517CC;
         5'd12: val = 32'h00028BE6;
         5'd13: val = 32'h000145F3;
         5'd14: val = 32'h0000A2FA;
         5'd15: val = 32'h0000517D;
         5'd16: val = 32'h000028BE;
         5'd17: val = 32'h0000145F;
         5'd18: val = 32'h00000A30;
         5'd19: val = 32'h00000518;
         5'd20: val = 32'h0000028C;
         5'd21: val = 32'h00000146;
         5'd22: val = 32'h000000A3;
         5'd23: val = 32'h00000051;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

[sv/fmpd_req_if.sv]
// Request channel carrying one complex input sample.
interface fmpd_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [fmpd_pkg::SAMPLE_BITS-1:0] in_real;
   logic signed [fmpd_pkg::SAMPLE_BITS-1:0] in_imag;

   modport source (output valid, output in_real, output in_imag, input ready);
   modport sink   (input valid, input in_real, input in_imag, output ready);
endinterface

[sv/fmpd_rsp_if.sv]
// Response channel carrying one averaged phase word.
interface fmpd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [fmpd_pkg::OUT_W-1:0] phase_word;

   modport source (output valid, output phase_word, input ready);
   modport sink   (input valid, input phase_word, output ready);
endinterface

[sv/fmpd_csr_if.sv]
// Configuration write channel carrying the output format bit.
interface fmpd_csr_if;
   logic valid;
   logic ready;
   logic output_format;

   modport source (output valid, output output_format, input ready);
   modport sink   (input valid, input output_format, output ready);
endinterface

[sv/fmpd_front.sv]
// Front end that sums each group of input samples and hands the group sum to the queue.
module fmpd_front (
   input  logic                         clock,
   input  logic                         reset,
   fmpd_req_if.sink                     req,
   output fmpd_pkg::fmpd_group_msg_type grp_out,
   input  logic                         grp_ready
);
   import fmpd_pkg::*;

   logic signed [ACC_W-1:0] acc_re_ff, acc_re_in;
   logic signed [ACC_W-1:0] acc_im_ff, acc_im_in;
   logic [CNT1_W-1:0]       cnt_ff, cnt_in;
   logic signed [ACC_W-1:0] sum_re;
   logic signed [ACC_W-1:0] sum_im;
   logic                    accept;
   logic                    group_end;

   assign req.ready = grp_ready;
   assign accept    = req.valid && grp_ready;
   assign group_end = (cnt_ff == CNT1_W'(FIRST_DECIMATION - 1));

   always_comb begin
      sum_re = acc_re_ff + ACC_W'(req.in_real);
      sum_im = acc_im_ff + ACC_W'(req.in_imag);
      grp_out.valid   = accept && group_end;
      grp_out.data.re = sum_re;
      grp_out.data.im = sum_im;
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         if (group_end) begin
            acc_re_in = '0;
            acc_im_in = '0;
            cnt_in    = '0;
         end else begin
            acc_re_in = sum_re;
            acc_im_in = sum_im;
            cnt_in    = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

[sv/fmpd_queue.sv]
// Two-entry queue of group sums between the front end and the back end.
module fmpd_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  fmpd_pkg::fmpd_group_msg_type push,
   output logic                         push_ready,
   output fmpd_pkg::fmpd_group_msg_type pop,
   input  logic                         pop_ready
);
   import fmpd_pkg::*;

   fmpd_group_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           do_push;
   logic           do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop.valid && pop_ready;
   assign pop.valid  = (count_ff != 2'd0);
   assign pop.data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("Queue count went past its depth.");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("Empty queue has mismatched pointers.");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !do_pop) |=> (count_ff == 2'd2))
      else $error("Full queue lost an entry without a pop.");

endmodule

[sv/fmpd_back.sv]
// Back end: conjugate product, iterative CORDIC angle, angle averaging and output register.
module fmpd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  fmpd_pkg::fmpd_group_msg_type grp_in,
   output logic                         grp_ready,
   input  fmpd_pkg::fmpd_format_type    fmt,
   fmpd_rsp_if.source                   rsp
);
   import fmpd_pkg::*;

   localparam logic signed [Z_W-1:0]    PI_Z    = Z_W'(64'sd1 <<< 31);
   localparam logic signed [Z_W-1:0]    HALF_Z  = Z_W'(64'sd1 <<< (ROUND_SH - 1));
   localparam logic signed [ASUM_W-1:0] AVG_HI  = ASUM_W'(32768);
   localparam logic signed [ASUM_W-1:0] AVG_LO  = -ASUM_W'(32768);
   localparam logic [CLAMP_W-1:0]       HALF_C  = CLAMP_W'(32768);
   localparam logic [OUT_W-1:0]         Q15_MAX = OUT_W'(32767);

   fmpd_state_type               state_ff, state_in;
   fmpd_group_type               cur_ff;
   logic signed [ACC_W-1:0]      last_re_ff, last_im_ff;
   logic signed [PROD_W-1:0]     p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff;
   logic signed [CORDIC_W-1:0]   x_ff, y_ff;
   logic signed [Z_W-1:0]        z_ff;
   logic                         zero_ff;
   logic [STEP_W-1:0]            step_ff;
   logic signed [ASUM_W-1:0]     asum_ff, asum_in;
   logic [CNT2_W-1:0]            cnt2_ff, cnt2_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]      rsp_word_ff;

   logic                         out_load;
   logic                         iter_last;
   logic                         avg_last;
   logic signed [SUMP_W-1:0]     pr_sum, pi_sum;
   logic signed [CORDIC_W-1:0]   dx, dy;
   logic signed [Z_W-1:0]        atan_z;
   logic signed [Z_W-1:0]        z_round;
   logic signed [ANGLE_W-1:0]    angle;
   logic signed [ASUM_W-1:0]     avg;
   logic [CLAMP_W-1:0]           clamp_v;
   logic [CLAMP_W-1:0]           offset_v;
   logic [CLAMP_W+7:0]           scaled;
   logic signed [OUT_W-1:0]      word;

   assign iter_last = (step_ff == STEP_W'(CORDIC_STEPS - 1));
   assign avg_last  = (cnt2_ff == CNT2_W'(SECOND_DECIMATION - 1));

   always_comb begin
      grp_ready = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: grp_ready = 1'b1;
         ST_OUT:  out_load  = !rsp_valid_ff || rsp.ready;
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (grp_in.valid) state_in = ST_MUL;
         ST_MUL:  state_in = ST_PREP;
         ST_PREP: state_in = ST_ROT;
         ST_ROT:  state_in = ST_ITER;
         ST_ITER: if (iter_last) state_in = ST_DONE;
         ST_DONE: state_in = avg_last ? ST_OUT : ST_IDLE;
         ST_OUT:  if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pr_sum  = SUMP_W'(p_rr_ff) + SUMP_W'(p_ii_ff);
      pi_sum  = SUMP_W'(p_ir_ff) - SUMP_W'(p_ri_ff);
      dx      = y_ff >>> step_ff;
      dy      = x_ff >>> step_ff;
      atan_z  = Z_W'(atan_lookup(ATAN_IDX_W'(step_ff)));
      z_round = z_ff + HALF_Z;
      angle   = zero_ff ? '0 : z_round[Z_W-1:ROUND_SH];

      asum_in = asum_ff;
      cnt2_in = cnt2_ff;
      if (state_ff == ST_DONE) begin
         asum_in = asum_ff + ASUM_W'(angle);
         cnt2_in = avg_last ? '0 : cnt2_ff + 1'b1;
      end else if (out_load) begin
         asum_in = '0;
      end

      avg = asum_ff >>> AVG_SHIFT;
      if (avg > AVG_HI) begin
         clamp_v = CLAMP_W'(AVG_HI);
      end else if (avg < AVG_LO) begin
         clamp_v = CLAMP_W'(AVG_LO);
      end else begin
         clamp_v = CLAMP_W'(avg);
      end
      offset_v = clamp_v + HALF_C;
      scaled   = {offset_v, 8'b0} - (CLAMP_W + 8)'(offset_v);

      case (fmt)
         FMT_BYTE: word = OUT_W'(scaled[CLAMP_W+6:CLAMP_W-1]);
         default:  word = (clamp_v == HALF_C) ? Q15_MAX : clamp_v[OUT_W-1:0];
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (grp_in.valid) cur_ff <= grp_in.data;
            step_ff <= '0;
         end
         ST_MUL: begin
            p_rr_ff <= cur_ff.re * last_re_ff;
            p_ii_ff <= cur_ff.im * last_im_ff;
            p_ir_ff <= cur_ff.im * last_re_ff;
            p_ri_ff <= cur_ff.re * last_im_ff;
         end
         ST_PREP: begin
            x_ff <= CORDIC_W'(pr_sum);
            y_ff <= CORDIC_W'(pi_sum);
         end
         ST_ROT: begin
            zero_ff <= (x_ff == '0) && (y_ff == '0);
            if (x_ff[CORDIC_W-1]) begin
               x_ff <= -x_ff;
               y_ff <= -y_ff;
               z_ff <= y_ff[CORDIC_W-1] ? -PI_Z : PI_Z;
            end else begin
               z_ff <= '0;
            end
         end
         ST_ITER: begin
            step_ff <= step_ff + 1'b1;
            if (!y_ff[CORDIC_W-1] && (y_ff != '0)) begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + atan_z;
            end else begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - atan_z;
            end
         end
         default: ;
      endcase
      if (out_load) rsp_word_ff <= word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_re_ff   <= '0;
         last_im_ff   <= '0;
         asum_ff      <= '0;
         cnt2_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         asum_ff      <= asum_in;
         cnt2_ff      <= cnt2_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_MUL) begin
            last_re_ff <= cur_ff.re;
            last_im_ff <= cur_ff.im;
         end
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.phase_word = rsp_word_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER) |-> (step_ff <= STEP_W'(CORDIC_STEPS - 1)))
      else $error("CORDIC step counter ran past the last step.");
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("Response appeared without an averaging result.");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && avg_last) |=> (state_ff == ST_OUT && cnt2_ff == '0))
      else $error("Completed angle group did not lead to a response.");

endmodule

[sv/fm_phase_discriminator_decimating_unit.sv]
// Top level of the decimating FM phase discriminator.
// The block sums each run of 11 I/Q requests into one group sample, takes the angle of that
// sample times the conjugate of the previous one with a 16-step CORDIC, and averages four
// angles into one phase word, so one response leaves per 44 accepted requests. Requests are
// taken one per cycle while the two-entry group queue has room; the back end takes one group
// at a time through its multiply, prepare, rotate, iterate and done states (and an output
// state when a response is formed), and its CORDIC stage runs one iteration per cycle. The
// format bit selects phase over pi in Q1.15 (0) or an offset byte (1); it is written through
// the csr channel, which is always ready, and resets to 0.
module fm_phase_discriminator_decimating_unit (
   input  logic       clock,
   input  logic       reset,
   fmpd_req_if.sink   req_chan,
   fmpd_rsp_if.source rsp_chan,
   fmpd_csr_if.sink   csr_chan
);
   import fmpd_pkg::*;

   fmpd_format_type    format_ff, format_in;
   fmpd_group_msg_type front_msg;
   fmpd_group_msg_type back_msg;
   logic               front_ready;
   logic               back_ready;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      format_in = format_ff;
      if (csr_chan.valid) format_in = fmpd_format_type'(csr_chan.output_format);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_Q15;
      end else begin
         format_ff <= format_in;
      end
   end

   fmpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .grp_out   (front_msg),
      .grp_ready (front_ready)
   );

   fmpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_msg),
      .push_ready (front_ready),
      .pop        (back_msg),
      .pop_ready  (back_ready)
   );

   fmpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .grp_in    (back_msg),
      .grp_ready (back_ready),
      .fmt       (format_ff),
      .rsp       (rsp_chan)
   );

endmodule

[verif/tb_fm_phase_discriminator_decimating_unit.sv]
// Self-checking testbench of the decimating FM phase discriminator with a built-in phase predictor.
`timescale 1ns / 100ps

module tb_fm_phase_discriminator_decimating_unit;
   import fmpd_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 400;
   localparam int GROUP_REQS    = FIRST_DECIMATION * SECOND_DECIMATION;
   localparam int MEAN_SHIFT    = $clog2(SECOND_DECIMATION + 1) - 1;
   localparam int PHASE_COUNT   = 3;
   localparam int RECORDS       = 9;

   localparam longint ARCTAN_STEP [0:23] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
      64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
   };

   localparam logic signed [15:0] RAIL_VALUES [0:4] = '{-32768, -1, 0, 1, 32767};

   typedef struct packed {
      fmpd_format_type    fmt;
      logic signed [15:0] a_re;
      logic signed [15:0] a_im;
      logic signed [15:0] b_re;
      logic signed [15:0] b_im;
      logic               fixed;
      logic signed [15:0] word;
   } tone_row_type;

   // Each row feeds one output period, alternating groups of sample a and sample b.
   localparam tone_row_type TONE_ROWS [0:11] = '{
      '{FMT_Q15,   32767,      0,  32767,      0, 1'b0,     0},
      '{FMT_Q15,  -32767,      0,  32767,      0, 1'b1, 32767},
      '{FMT_BYTE, -32767,      0,  32767,      0, 1'b1,   255},
      '{FMT_BYTE,      0,      0,      0,      0, 1'b1,   127},
      '{FMT_Q15,       0,      0,      0,      0, 1'b1,     0},
      '{FMT_Q15,  -32768, -32768,  32767,  32767, 1'b0,     0},
      '{FMT_Q15,   32767, -32768, -32768,  32767, 1'b0,     0},
      '{FMT_BYTE,      0,  32767, -32768,      0, 1'b0,     0},
      '{FMT_BYTE,      0, -32768,  32767,     -1, 1'b0,     0},
      '{FMT_BYTE,      1,      0,      0,      1, 1'b0,     0},
      '{FMT_Q15,      -1,     -1,      1,     -1, 1'b0,     0},
      '{FMT_Q15,   32767,  32767, -32768, -32768, 1'b0,     0}
   };

   logic clock = 1'b0;
   logic reset;

   fmpd_req_if req_bus ();
   fmpd_rsp_if rsp_bus ();
   fmpd_csr_if csr_bus ();

   fm_phase_discriminator_decimating_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #5 clock = ~clock;

   logic signed [15:0] phase_q [$];
   int                 mismatch_count = 0;
   int                 cycle_count    = 0;
   int                 send_idle_pct;
   int                 recv_idle_pct;
   int                 stall_orders   = 0;
   int                 stall_served   = 0;
   int                 stall_left     = 0;

   fmpd_format_type format_bit  = FMT_Q15;
   longint          sum_re      = 0;
   longint          sum_im      = 0;
   int              sum_count   = 0;
   longint          prev_re     = 0;
   longint          prev_im     = 0;
   longint          angle_acc   = 0;
   int              angle_count = 0;

   // Vectoring CORDIC angle in units of pi/32768.
   function automatic longint cordic_phase(input longint x_in, input longint y_in);
      longint x, y, z, dx, dy;
      int     k;
      x = x_in;
      y = y_in;
      z = 0;
      if (x == 0 && y == 0)
         return 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = (y <= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
      end
      for (k = 0; k < CORDIC_STEPS && k < 24; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (y > 0) begin
            x += dx;
            y -= dy;
            z += ARCTAN_STEP[k];
         end else begin
            x -= dx;
            y += dy;
            z -= ARCTAN_STEP[k];
         end
      end
      return (z + 64'sd32768) >>> 16;
   endfunction

   function automatic void predict_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                                          input logic fixed, input logic signed [15:0] fixed_word);
      longint             xr, xi, pr, pq, mean;
      logic signed [15:0] word;
      sum_re += longint'(re);
      sum_im += longint'(im);
      if (sum_count + 1 < FIRST_DECIMATION) begin
         sum_count++;
         return;
      end
      xr        = sum_re;
      xi        = sum_im;
      sum_re    = 0;
      sum_im    = 0;
      sum_count = 0;
      pr        = xr * prev_re + xi * prev_im;
      pq        = xi * prev_re - xr * prev_im;
      prev_re   = xr;
      prev_im   = xi;
      angle_acc += cordic_phase(pr, pq);
      if (angle_count + 1 < SECOND_DECIMATION) begin
         angle_count++;
         return;
      end
      mean        = angle_acc >>> MEAN_SHIFT;
      angle_acc   = 0;
      angle_count = 0;
      if (mean > 32768)
         mean = 32768;
      if (mean < -32768)
         mean = -32768;
      if (format_bit == FMT_BYTE)
         word = 16'(((mean + 32768) * 255) >>> 16);
      else
         word = 16'((mean > 32767) ? 64'sd32767 : mean);
      phase_q.push_back(fixed ? fixed_word : word);
   endfunction

   task automatic push_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                              input logic fixed, input logic signed [15:0] fixed_word);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_real <= re;
      req_bus.in_imag <= im;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predict_sample(re, im, fixed, fixed_word);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (phase_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_format(input fmpd_format_type fmt);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_bus.valid         <= 1'b1;
      csr_bus.output_format <= fmt;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      csr_bus.valid <= 1'b0;
      format_bit = fmt;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (phase_q.size() == 0) begin
            $display("%0t: phase word with none expected, actual %0d", $time,
                     rsp_bus.phase_word);
            mismatch_count++;
         end else begin
            if (rsp_bus.phase_word !== phase_q[0]) begin
               $display("%0t: phase word mismatch, expected %0d actual %0d", $time,
                        phase_q[0], rsp_bus.phase_word);
               mismatch_count++;
            end
            void'(phase_q.pop_front());
         end
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_orders != stall_served) begin
         stall_served  <= stall_orders;
         stall_left    <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left    <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("fm_phase_discriminator_decimating_unit regression: fail");
         $finish;
      end
   end

   initial begin
      tone_row_type       row;
      real                ph, step, amp;
      int                 r, n, phase, rec, mode;
      logic signed [15:0] s_re, s_im;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.in_real       = '0;
      req_bus.in_imag       = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.output_format = 1'b0;
      send_idle_pct         = 30;
      recv_idle_pct         = 56;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < 12; r++) begin
         row = TONE_ROWS[r];
         if (row.fmt != format_bit)
            set_format(row.fmt);
         for (n = 0; n < GROUP_REQS; n++) begin
            if ((n / FIRST_DECIMATION) % 2 == 0)
               push_sample(row.a_re, row.a_im, row.fixed, row.word);
            else
               push_sample(row.b_re, row.b_im, row.fixed, row.word);
         end
      end

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 56 : 0;
         recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 30 : 0;
         if (phase == 0)
            set_format(FMT_BYTE);
         else if (phase == 1)
            set_format(FMT_Q15);
         else
            set_format(fmpd_format_type'($urandom_range(1, 0)));
         for (rec = 0; rec < RECORDS; rec++) begin
            if (phase == 2 && rec == 3)
               stall_orders <= stall_orders + 1;
            if (phase == 1 && rec == 6)
               drain_results();
            mode = $urandom_range(9, 0);
            if ($urandom_range(3, 0) == 0)
               amp = real'($urandom_range(64, 1));
            else
               amp = real'($urandom_range(32767, 1));
            ph   = 6.283185 * real'($urandom_range(999, 0)) / 1000.0;
            step = 0.4 * (real'($urandom_range(2000, 0)) - 1000.0) / 1000.0;
            for (n = 0; n < GROUP_REQS; n++) begin
               if (n % FIRST_DECIMATION == 0)
                  step += 0.05 * (real'($urandom_range(200, 0)) - 100.0) / 100.0;
               ph += step;
               if (mode <= 6) begin
                  s_re = 16'($rtoi(amp * $cos(ph)));
                  s_im = 16'($rtoi(amp * $sin(ph)));
               end else if (mode <= 8) begin
                  s_re = 16'($urandom);
                  s_im = 16'($urandom);
               end else begin
                  s_re = RAIL_VALUES[$urandom_range(4, 0)];
                  s_im = RAIL_VALUES[$urandom_range(4, 0)];
               end
               push_sample(s_re, s_im, 1'b0, 16'sd0);
            end
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("fm_phase_discriminator_decimating_unit regression: pass");
      else
         $display("fm_phase_discriminator_decimating_unit regression: fail");
      $finish;
   end

endmodule
